>>> hdl/gtg_pkg.sv
// Shared types and constants for the go-to-goal controller.
// Holds the CORDIC datapath widths, the arctangent table and the register map.
// No dependencies.
package gtg_pkg;

  // Datapath widths of the CORDIC vector (x, y) and angle accumulator (z).
  localparam int XW = 28;
  localparam int ZW = 21;

  // Pi in Q.16 radians and the inverse CORDIC gain in Q0.16.
  localparam logic signed [ZW-1:0] PI_Q16       = 21'sd205887;
  localparam logic        [15:0]   INV_GAIN_Q16 = 16'd39797;

  // Registered steps around the cell chain: one entry step, four exit steps.
  localparam int PIPE_EXTRA = 5;

  // Configuration register map.
  typedef enum logic [2:0] {
    REG_TARGET_X   = 3'd0,
    REG_TARGET_Y   = 3'd1,
    REG_SPEED_GAIN = 3'd2,
    REG_MAX_SPEED  = 3'd3,
    REG_DIST_THR   = 3'd4,
    REG_ANGLE_THR  = 3'd5
  } gtg_reg_t;

  // Vector state handed from one CORDIC cell to the next.
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic signed [14:0]   heading;
  } gtg_vec_t;

  // Settings used by the decision stages after the chain.
  typedef struct packed {
    logic [15:0] speed_gain;
    logic [14:0] max_speed;
    logic [14:0] dist_thr;
    logic [14:0] angle_thr;
  } gtg_cfg_t;

  // Arctangent of 2^-i in Q.16 radians.
  function automatic logic signed [ZW-1:0] gtg_atan(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:       v = 21'sd51472;
      1:       v = 21'sd30386;
      2:       v = 21'sd16055;
      3:       v = 21'sd8150;
      4:       v = 21'sd4091;
      5:       v = 21'sd2047;
      6:       v = 21'sd1024;
      7:       v = 21'sd512;
      8:       v = 21'sd256;
      9:       v = 21'sd128;
      10:      v = 21'sd64;
      11:      v = 21'sd32;
      12:      v = 21'sd16;
      13:      v = 21'sd8;
      14:      v = 21'sd4;
      15:      v = 21'sd2;
      16:      v = 21'sd1;
      default: v = 21'sd0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/gtg_cordic_cell.sv
// One vectoring micro-rotation of the CORDIC chain, registered at its output.
// Depends on gtg_pkg for the vector type and the arctangent table.
module gtg_cordic_cell
  import gtg_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  gtg_vec_t in_vec,
  output logic     out_valid,
  output gtg_vec_t out_vec
);

  localparam logic signed [ZW-1:0] ATAN = gtg_atan(STAGE);

  logic signed [XW-1:0] x_in;
  logic signed [XW-1:0] y_in;
  logic signed [XW-1:0] x_sh;
  logic signed [XW-1:0] y_sh;
  gtg_vec_t             vec_nxt;
  gtg_vec_t             vec_r;
  logic                 valid_r;

  // Rotate toward the x axis; both shifts use the incoming x and y.
  always_comb begin
    x_in = in_vec.x;
    y_in = in_vec.y;
    x_sh = x_in >>> STAGE;
    y_sh = y_in >>> STAGE;
    vec_nxt = in_vec;
    if (!y_in[XW-1]) begin
      vec_nxt.x = x_in + y_sh;
      vec_nxt.y = y_in - x_sh;
      vec_nxt.z = in_vec.z + ATAN;
    end else begin
      vec_nxt.x = x_in - y_sh;
      vec_nxt.y = y_in + x_sh;
      vec_nxt.z = in_vec.z - ATAN;
    end
  end

  // Valid flag is reset; the vector itself needs none.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    vec_r <= vec_nxt;
  end

  assign out_valid = valid_r;
  assign out_vec   = vec_r;

endmodule

>>> hdl/gtg_post.sv
// Exit stages: distance scaling, bearing error, speed product and decision.
// Depends on gtg_pkg for the vector and settings types.
module gtg_post
  import gtg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  gtg_vec_t    in_vec,
  input  gtg_cfg_t    cfg,
  output logic        out_valid,
  output logic [14:0] out_linear_speed,
  output logic [14:0] out_angular_speed,
  output logic        out_at_goal
);

  localparam int PW = XW - 1 + 16;   // magnitude times inverse gain
  localparam int DW = PW - 24;       // distance in Q11.8
  localparam int LW = 16 + DW;       // gain times distance

  // Step 1: magnitude product and absolute heading error.
  logic [XW-2:0]        mag_u;
  logic signed [ZW-1:0] z_rnd;
  logic signed [ZW-1:0] bearing;
  logic signed [ZW:0]   err;
  logic [ZW-1:0]        err_abs;
  logic [PW-1:0]        prod1_r;
  logic [ZW-1:0]        err1_r;
  logic                 v1_r;

  always_comb begin
    mag_u   = in_vec.x[XW-2:0];
    z_rnd   = in_vec.z + ZW'(8);
    bearing = z_rnd >>> 4;
    err     = {bearing[ZW-1], bearing} - (ZW+1)'(in_vec.heading);
    err_abs = err[ZW] ? ZW'(-err) : err[ZW-1:0];
  end

  always_ff @(posedge clk) begin
    prod1_r <= PW'(mag_u) * PW'(INV_GAIN_Q16);
    err1_r  <= err_abs;
  end

  // Step 2: round the distance and compare both thresholds.
  logic [PW-1:0] prod_rnd;
  logic [DW-1:0] dist_q;
  logic [DW-1:0] dist2_r;
  logic [ZW-1:0] err2_r;
  logic          far2_r;
  logic          turn2_r;
  logic          v2_r;

  always_comb begin
    prod_rnd = prod1_r + (PW'(1) << 23);
    dist_q   = prod_rnd[PW-1:24];
  end

  always_ff @(posedge clk) begin
    dist2_r <= dist_q;
    err2_r  <= err1_r;
    far2_r  <= dist_q > DW'(cfg.dist_thr);
    turn2_r <= err1_r > ZW'(cfg.angle_thr);
  end

  // Step 3: linear speed product.
  logic [LW-1:0] lin3_r;
  logic [14:0]   ang3_r;
  logic          far3_r;
  logic          turn3_r;
  logic          v3_r;

  always_ff @(posedge clk) begin
    lin3_r  <= LW'(cfg.speed_gain) * LW'(dist2_r);
    ang3_r  <= err2_r[14:0];
    far3_r  <= far2_r;
    turn3_r <= turn2_r;
  end

  // Step 4: round, clamp and select the command.
  logic [LW-1:0] lin_rnd;
  logic [LW-13:0] lin_q;
  logic [14:0]   lin_sat;
  logic [14:0]   lin_r;
  logic [14:0]   ang_r;
  logic          goal_r;
  logic          v4_r;

  always_comb begin
    lin_rnd = lin3_r + LW'(2048);
    lin_q   = lin_rnd[LW-1:12];
    lin_sat = (lin_q > (LW-12)'(cfg.max_speed)) ? cfg.max_speed : lin_q[14:0];
  end

  always_ff @(posedge clk) begin
    lin_r  <= (far3_r && !turn3_r) ? lin_sat : 15'd0;
    ang_r  <= (far3_r && turn3_r) ? ang3_r : 15'd0;
    goal_r <= !far3_r;
  end

  // Valid flags through the four steps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign out_valid         = v4_r;
  assign out_linear_speed  = lin_r;
  assign out_angular_speed = ang_r;
  assign out_at_goal       = goal_r;

endmodule

>>> hdl/go_to_goal_controller.sv
// Top level of the go-to-goal controller: settings registers, entry step,
// CORDIC cell chain and exit stages. Depends on gtg_pkg, gtg_cordic_cell and gtg_post.
//
// A pose is taken on every cycle in which start is high; busy stays low, so
// the block sustains one pose per clock. Each pose yields exactly one result,
// shown with out_valid for a single cycle once it has passed the registered
// steps: one entry step, one cell per CORDIC stage, and four exit steps
// (distance scaling, threshold compare, speed product, clamp and select).
// The latency grows with the length of the cell chain. Results cannot be held
// off, so the receiver must take each one in the cycle it appears. Settings
// are written through the cfg_ port, which is always ready, and must only be
// changed while no pose is in flight.
module go_to_goal_controller
  import gtg_pkg::*;
#(
  parameter int CORDIC_STAGES = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_pos_x,
  input  logic [15:0] in_pos_y,
  input  logic [14:0] in_heading,
  output logic        out_valid,
  output logic [14:0] out_linear_speed,
  output logic [14:0] out_angular_speed,
  output logic        out_at_goal,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Settings registers.
  logic [15:0] target_x_r;
  logic [15:0] target_y_r;
  logic [15:0] speed_gain_r;
  logic [14:0] max_speed_r;
  logic [14:0] dist_thr_r;
  logic [14:0] angle_thr_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_x_r   <= 16'd256;
      target_y_r   <= 16'd256;
      speed_gain_r <= 16'd4096;
      max_speed_r  <= 15'd768;
      dist_thr_r   <= 15'd26;
      angle_thr_r  <= 15'd819;
    end else if (cfg_valid && cfg_ready) begin
      case (gtg_reg_t'(cfg_index))
        REG_TARGET_X:   target_x_r   <= cfg_data;
        REG_TARGET_Y:   target_y_r   <= cfg_data;
        REG_SPEED_GAIN: speed_gain_r <= cfg_data;
        REG_MAX_SPEED:  max_speed_r  <= cfg_data[14:0];
        REG_DIST_THR:   dist_thr_r   <= cfg_data[14:0];
        REG_ANGLE_THR:  angle_thr_r  <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Entry step: offset to the target, scaled and folded into the right half plane.
  logic signed [16:0]   dx;
  logic signed [16:0]   dy;
  logic signed [XW-1:0] x0;
  logic signed [XW-1:0] y0;
  gtg_vec_t             entry_nxt;

  always_comb begin
    dx = {target_x_r[15], target_x_r} - {in_pos_x[15], in_pos_x};
    dy = {target_y_r[15], target_y_r} - {in_pos_y[15], in_pos_y};
    x0 = XW'($signed({dx, 8'b0}));
    y0 = XW'($signed({dy, 8'b0}));
    entry_nxt.heading = in_heading;
    if (dx[16]) begin
      entry_nxt.x = -x0;
      entry_nxt.y = -y0;
      entry_nxt.z = dy[16] ? -PI_Q16 : PI_Q16;
    end else begin
      entry_nxt.x = x0;
      entry_nxt.y = y0;
      entry_nxt.z = '0;
    end
  end

  gtg_vec_t stage_vec [0:CORDIC_STAGES];
  logic     stage_v   [0:CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v[0] <= 1'b0;
    end else begin
      stage_v[0] <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    stage_vec[0] <= entry_nxt;
  end

  // Chain of micro-rotation cells.
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    gtg_cordic_cell #(
      .STAGE (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stage_v[g]),
      .in_vec    (stage_vec[g]),
      .out_valid (stage_v[g+1]),
      .out_vec   (stage_vec[g+1])
    );
  end

  // Exit stages.
  gtg_cfg_t post_cfg;

  assign post_cfg.speed_gain = speed_gain_r;
  assign post_cfg.max_speed  = max_speed_r;
  assign post_cfg.dist_thr   = dist_thr_r;
  assign post_cfg.angle_thr  = angle_thr_r;

  gtg_post u_post (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (stage_v[CORDIC_STAGES]),
    .in_vec            (stage_vec[CORDIC_STAGES]),
    .cfg               (post_cfg),
    .out_valid         (out_valid),
    .out_linear_speed  (out_linear_speed),
    .out_angular_speed (out_angular_speed),
    .out_at_goal       (out_at_goal)
  );

endmodule

>>> hdl/gtg_checker.sv
// Port-level checks for the go-to-goal controller, bound to the top level.
// Depends on gtg_pkg for the number of registered steps around the cell chain.
module gtg_checker
  import gtg_pkg::*;
#(
  parameter int CORDIC_STAGES = 14
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [14:0] out_linear_speed,
  input logic [14:0] out_angular_speed,
  input logic        out_at_goal
);

  localparam int LAT = CORDIC_STAGES + PIPE_EXTRA;

  // Every accepted pose produces a result after the fixed latency.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted pose produced no result");

  // No result appears without a pose accepted the fixed latency earlier.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching accepted pose");

  // At the goal both speed commands are zero.
  a_goal_still: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_at_goal) |-> (out_linear_speed == 15'd0 && out_angular_speed == 15'd0))
    else $error("nonzero speed at goal");

  // The block either turns or drives, never both.
  a_turn_or_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_linear_speed == 15'd0 || out_angular_speed == 15'd0))
    else $error("turning and driving at once");

endmodule

bind go_to_goal_controller gtg_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_gtg_checker (.*);
